// ===== sv/merge_two_sorted_sequences_defines.svh =====
// Assertion macros for the two-sequence merger.
// Used by files that check their own logic; relies on clk and arst_n in scope.
`ifndef MERGE_TWO_SORTED_SEQUENCES_DEFINES_SVH
`define MERGE_TWO_SORTED_SEQUENCES_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MTSS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MTSS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/mtss_pkg.sv =====
// Shared types and codes for the two-sequence merger.
// No dependencies.
package mtss_pkg;

	localparam int DATA_W = 32;

	typedef enum logic [1:0] {
		CMD_APPEND_FIRST  = 2'd0,
		CMD_APPEND_SECOND = 2'd1,
		CMD_START         = 2'd2
	} cmd_t;

	// Result of one compare-and-select step.
	typedef struct packed {
		logic              take_first;
		logic [DATA_W-1:0] value;
	} pick_t;

endpackage

// ===== sv/merge_two_sorted_sequences.sv =====
// Two-sequence merger top level: sequencer, two element buffers, compare unit.
// Depends on mtss_pkg, mtss_buf, mtss_cmp and merge_two_sorted_sequences_defines.svh.
//
// Usage:
//   Input channel s_*: tdata carries elem_value, tuser carries cmd. Command 0
//   appends to the first buffer, 1 to the second, 2 starts the merge, 3 is
//   ignored. Appends to a full buffer are dropped and set a sticky
//   overflow flag.
//   Output channel m_*: tdata carries out_value, tlast marks the final result
//   of a run, tuser[0] is is_empty and tuser[1] is had_overflow.
//   A start first prefetches both heads from the buffers, then emits one
//   result per cycle while the receiver does not stall, each chosen by the
//   single compare unit from the registered buffer reads (one result when
//   both buffers are empty). s_tready is low from start until the last result
//   enters the output register; both buffers and the flag then clear.
//   When the receiver stalls, the sequencer holds its read positions and the
//   output register holds its item. Appends may arrive while the last result
//   still waits in the output register.
//   Reset clears counts, flag and sequencer; buffer contents need no clearing.
`include "merge_two_sorted_sequences_defines.svh"

module merge_two_sorted_sequences #(
	parameter int SEQ_DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic signed [31:0] s_tdata,  // [31:0] elem_value
	input  logic [1:0]         s_tuser,  // [1:0] cmd
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic signed [31:0] m_tdata,  // [31:0] out_value
	output logic               m_tlast,
	output logic [1:0]         m_tuser   // [0] is_empty, [1] had_overflow
);

	localparam int CNT_W = $clog2(SEQ_DEPTH + 1);
	localparam int IDX_W = (SEQ_DEPTH > 1) ? $clog2(SEQ_DEPTH) : 1;
	localparam int SUM_W = CNT_W + 1;
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(SEQ_DEPTH);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_PREP  = 3'b010,
		ST_MERGE = 3'b100
	} state_t;

	state_t                      state_q;
	logic [CNT_W-1:0]            cnt_a_q, cnt_b_q;
	logic [CNT_W-1:0]            i_q, j_q;
	logic                        ovf_q;
	logic                        m_tvalid_q;
	logic [mtss_pkg::DATA_W-1:0] m_data_q;
	logic                        m_last_q;
	logic [1:0]                  m_user_q;

	logic                        in_acc;
	mtss_pkg::cmd_t              cmd;
	logic                        full_a, full_b;
	logic                        wr_a, wr_b;
	logic                        a_avail, b_avail;
	logic                        both_empty;
	logic                        slot_free, emit, adv_a, adv_b, last;
	logic [CNT_W-1:0]            i_next, j_next;
	logic [IDX_W-1:0]            rd_addr_a, rd_addr_b;
	logic [mtss_pkg::DATA_W-1:0] head_a, head_b;
	mtss_pkg::pick_t             pick;

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign cmd      = mtss_pkg::cmd_t'(s_tuser);

	assign full_a = (cnt_a_q >= DEPTH_C);
	assign full_b = (cnt_b_q >= DEPTH_C);
	assign wr_a   = in_acc && (cmd == mtss_pkg::CMD_APPEND_FIRST) && !full_a;
	assign wr_b   = in_acc && (cmd == mtss_pkg::CMD_APPEND_SECOND) && !full_b;

	assign a_avail    = (i_q < cnt_a_q);
	assign b_avail    = (j_q < cnt_b_q);
	assign both_empty = (cnt_a_q == '0) && (cnt_b_q == '0);

	// Emit only when the output register is free or is being drained.
	assign slot_free = !m_tvalid_q || m_tready;
	assign emit      = (state_q == ST_MERGE) && slot_free;
	assign adv_a     = emit && pick.take_first;
	assign adv_b     = emit && !pick.take_first && b_avail;
	assign last      = both_empty ||
		((SUM_W'(i_q) + SUM_W'(j_q) + SUM_W'(1)) == (SUM_W'(cnt_a_q) + SUM_W'(cnt_b_q)));

	// Read ahead: address the element that will be the head next cycle.
	assign i_next    = adv_a ? i_q + CNT_W'(1) : i_q;
	assign j_next    = adv_b ? j_q + CNT_W'(1) : j_q;
	assign rd_addr_a = (i_next < DEPTH_C) ? i_next[IDX_W-1:0] : '0;
	assign rd_addr_b = (j_next < DEPTH_C) ? j_next[IDX_W-1:0] : '0;

	mtss_buf #(
		.DEPTH(SEQ_DEPTH),
		.IDX_W(IDX_W)
	) u_buf_a (
		.clk    (clk),
		.wr_en  (wr_a),
		.wr_addr(cnt_a_q[IDX_W-1:0]),
		.wr_data(s_tdata),
		.rd_addr(rd_addr_a),
		.rd_data(head_a)
	);

	mtss_buf #(
		.DEPTH(SEQ_DEPTH),
		.IDX_W(IDX_W)
	) u_buf_b (
		.clk    (clk),
		.wr_en  (wr_b),
		.wr_addr(cnt_b_q[IDX_W-1:0]),
		.wr_data(s_tdata),
		.rd_addr(rd_addr_b),
		.rd_data(head_b)
	);

	mtss_cmp u_cmp (
		.head_a (head_a),
		.head_b (head_b),
		.a_avail(a_avail),
		.b_avail(b_avail),
		.pick   (pick)
	);

	// Sequencer, counts and sticky overflow.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_a_q <= '0;
			cnt_b_q <= '0;
			i_q     <= '0;
			j_q     <= '0;
			ovf_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (wr_a) begin
						cnt_a_q <= cnt_a_q + CNT_W'(1);
					end
					if (wr_b) begin
						cnt_b_q <= cnt_b_q + CNT_W'(1);
					end
					// Drop appends to a full buffer, remember it.
					if (in_acc && (((cmd == mtss_pkg::CMD_APPEND_FIRST) && full_a) ||
						((cmd == mtss_pkg::CMD_APPEND_SECOND) && full_b))) begin
						ovf_q <= 1'b1;
					end
					if (in_acc && (cmd == mtss_pkg::CMD_START)) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					// Heads at index zero arrive from the buffers this cycle.
					state_q <= ST_MERGE;
				end
				ST_MERGE: begin
					if (emit && last) begin
						cnt_a_q <= '0;
						cnt_b_q <= '0;
						i_q     <= '0;
						j_q     <= '0;
						ovf_q   <= 1'b0;
						state_q <= ST_IDLE;
					end else begin
						i_q <= i_next;
						j_q <= j_next;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (emit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			m_data_q <= both_empty ? '0 : pick.value;
			m_last_q <= last;
			m_user_q <= {ovf_q, both_empty};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = $signed(m_data_q);
	assign m_tlast  = m_last_q;
	assign m_tuser  = m_user_q;

	`MTSS_ASSERT_NOW(a_empty_is_last, m_tvalid && m_tuser[0], m_tlast, "empty result not last")
	`MTSS_ASSERT_NOW(a_cnt_bound, 1'b1, (cnt_a_q <= DEPTH_C) && (cnt_b_q <= DEPTH_C), "count overrun")
	`MTSS_ASSERT_NEXT(a_clear_after_last, emit && last, (cnt_a_q == '0) && (cnt_b_q == '0) && !ovf_q, "buffers not cleared after merge")
	`MTSS_ASSERT_NEXT(a_hold_on_stall, (state_q == ST_MERGE) && m_tvalid && !m_tready, $stable(i_q) && $stable(j_q), "read position moved during stall")

endmodule

// ===== sv/mtss_buf.sv =====
// Element buffer: one write port, one registered read port.
// Depends on mtss_pkg for the data width.
module mtss_buf #(
	parameter int DEPTH = 16,
	parameter int IDX_W = 4
) (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [IDX_W-1:0]           wr_addr,
	input  logic [mtss_pkg::DATA_W-1:0] wr_data,
	input  logic [IDX_W-1:0]           rd_addr,
	output logic [mtss_pkg::DATA_W-1:0] rd_data
);

	logic [mtss_pkg::DATA_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem_q[rd_addr];
	end

endmodule

// ===== sv/mtss_cmp.sv =====
// Shared compare-and-select unit: picks the next merged element.
// Depends on mtss_pkg for pick_t.
module mtss_cmp (
	input  logic [mtss_pkg::DATA_W-1:0] head_a,
	input  logic [mtss_pkg::DATA_W-1:0] head_b,
	input  logic                        a_avail,
	input  logic                        b_avail,
	output mtss_pkg::pick_t             pick
);

	logic a_less;

	// Ties go to the second sequence.
	assign a_less          = $signed(head_a) < $signed(head_b);
	assign pick.take_first = a_avail && (!b_avail || a_less);
	assign pick.value      = pick.take_first ? head_a : head_b;

endmodule

// ===== tb/merge_order_checker.sv =====
`timescale 1ns / 1ps
// Checker for the two-sequence merger: watches both stream channels.
// Predicts each merged run and compares results. Depends on mtss_pkg.
module merge_order_checker #(
	parameter int DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	input  logic               s_tready,
	input  logic signed [31:0] s_tdata,
	input  logic [1:0]         s_tuser,
	input  logic               m_tvalid,
	input  logic               m_tready,
	input  logic signed [31:0] m_tdata,
	input  logic               m_tlast,
	input  logic [1:0]         m_tuser,
	output int                 err_count,
	output int                 pending
);

	typedef struct packed {
		logic signed [31:0] value;
		logic               last;
		logic               empty;
		logic               dropped;
	} merged_t;

	merged_t            merged_q[$];
	logic signed [31:0] first_seq[DEPTH];
	logic signed [31:0] second_seq[DEPTH];
	int                 first_len;
	int                 second_len;
	logic               drop_seen;
	int                 errs;

	// Queue the whole merged run, then empty both sequences.
	task automatic predict_merge();
		int      i;
		int      j;
		int      total;
		merged_t r;
		i = 0;
		j = 0;
		total = first_len + second_len;
		r.empty = 1'b0;
		r.dropped = drop_seen;
		if (total == 0) begin
			r.value = '0;
			r.last = 1'b1;
			r.empty = 1'b1;
			merged_q.push_back(r);
		end
		while (i < first_len || j < second_len) begin
			// ties go to the second sequence
			if (i < first_len && (j >= second_len || first_seq[i] < second_seq[j])) begin
				r.value = first_seq[i];
				i++;
			end else begin
				r.value = second_seq[j];
				j++;
			end
			r.last = (i + j == total);
			merged_q.push_back(r);
		end
		first_len = 0;
		second_len = 0;
		drop_seen = 1'b0;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		merged_t got;
		merged_t want;
		if (!arst_n) begin
			merged_q.delete();
			first_len = 0;
			second_len = 0;
			drop_seen = 1'b0;
			errs = 0;
			err_count <= 0;
			pending <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.value = m_tdata;
				got.last = m_tlast;
				got.empty = m_tuser[0];
				got.dropped = m_tuser[1];
				if (merged_q.size() == 0) begin
					errs++;
					$display("%0t: unexpected result: value %0d last %0b empty %0b overflow %0b",
						$time, got.value, got.last, got.empty, got.dropped);
				end else begin
					want = merged_q.pop_front();
					if (got !== want) begin
						errs++;
						$display("%0t: mismatch: expected value %0d last %0b empty %0b overflow %0b",
							$time, want.value, want.last, want.empty, want.dropped);
						$display("%0t:          actual value %0d last %0b empty %0b overflow %0b",
							$time, got.value, got.last, got.empty, got.dropped);
					end
				end
			end
			if (s_tvalid && s_tready) begin
				case (s_tuser)
					mtss_pkg::CMD_APPEND_FIRST: begin
						if (first_len < DEPTH) begin
							first_seq[first_len] = s_tdata;
							first_len++;
						end else begin
							drop_seen = 1'b1;
						end
					end
					mtss_pkg::CMD_APPEND_SECOND: begin
						if (second_len < DEPTH) begin
							second_seq[second_len] = s_tdata;
							second_len++;
						end else begin
							drop_seen = 1'b1;
						end
					end
					mtss_pkg::CMD_START: predict_merge();
					default: ;
				endcase
			end
			err_count <= errs;
			pending <= merged_q.size();
		end
	end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the merger testbench: clock, reset, stimulus, receiver and verdict.
// Depends on mtss_pkg, merge_two_sorted_sequences and merge_order_checker.
module tb_top;

	localparam int               DEPTH      = 16;
	localparam int               QUIET_MAX  = 5000;
	localparam int               HOLD_LEN   = 300;
	localparam logic [1:0]       CMD_UNUSED = 2'd3;
	localparam logic signed [31:0] VAL_MIN  = 32'sh8000_0000;
	localparam logic signed [31:0] VAL_MAX  = 32'sh7fff_ffff;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic signed [31:0] s_tdata = '0;   // [31:0] elem_value
	logic [1:0]         s_tuser = '0;   // [1:0] cmd
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic signed [31:0] m_tdata;        // [31:0] out_value
	logic               m_tlast;
	logic [1:0]         m_tuser;        // [0] is_empty, [1] had_overflow

	int fails;
	int pending;
	int send_idle = 0;
	int recv_idle = 0;
	bit hold_req = 1'b0;
	int items_sent = 0;
	int quiet = 0;

	always #1 clk = ~clk;

	merge_two_sorted_sequences #(
		.SEQ_DEPTH(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.m_tuser(m_tuser)
	);

	merge_order_checker #(
		.DEPTH(DEPTH)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.m_tuser(m_tuser),
		.err_count(fails),
		.pending(pending)
	);

	// Offer one item, with random idle cycles ahead of it, and hold it until
	// the block takes it. Valid stays high afterwards so that back-to-back
	// items need no extra assignment; drain_results lowers it.
	task automatic send(input logic [1:0] cmd, input logic signed [31:0] value);
		while ($urandom_range(0, 99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= value;
		do @(posedge clk); while (!s_tready);
	endtask

	// Stop offering and wait until every predicted result has been taken.
	// The first edge lets the checker count the item just accepted.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// Mostly short sequences; now and then long ones or ones that overrun.
	function automatic int pick_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return $urandom_range(0, 5);
		else if (r < 93)
			return $urandom_range(6, DEPTH);
		else
			return $urandom_range(DEPTH + 1, DEPTH + 2);
	endfunction

	// Build an ascending run: narrow around zero (many ties), spread over
	// the whole range (saturating at the top), or now and then unsorted.
	function automatic void fill_seq(output logic signed [31:0] vals[DEPTH + 2], input int n);
		longint      acc;
		int unsigned step_max;
		int          mode;
		mode = $urandom_range(0, 9);
		if (mode < 4) begin
			acc = longint'($urandom_range(0, 40)) - 20;
			step_max = 3;
		end else begin
			acc = longint'(VAL_MIN) + longint'($urandom_range(0, 32'h7fff_ffff));
			if ($urandom_range(0, 3) == 0)
				acc = longint'(VAL_MIN);
			step_max = 32'h2000_0000;
		end
		for (int k = 0; k < n; k++) begin
			vals[k] = (mode == 9) ? $urandom : acc[31:0];
			acc = acc + longint'($urandom_range(0, step_max));
			if (acc > longint'(VAL_MAX))
				acc = longint'(VAL_MAX);
		end
	endfunction

	// One merge round: interleave the appends of two runs at random, drop in
	// an ignored code now and then, and usually close with a start. A round
	// left open carries its elements into the next one.
	task automatic run_round();
		logic signed [31:0] run_a[DEPTH + 2];
		logic signed [31:0] run_b[DEPTH + 2];
		int                 na;
		int                 nb;
		int                 ia;
		int                 ib;
		na = pick_len();
		nb = pick_len();
		fill_seq(run_a, na);
		fill_seq(run_b, nb);
		ia = 0;
		ib = 0;
		while (ia < na || ib < nb) begin
			if ($urandom_range(0, 19) == 0)
				send(CMD_UNUSED, $urandom);
			if (ib >= nb || (ia < na && $urandom_range(0, 1) == 1)) begin
				send(mtss_pkg::CMD_APPEND_FIRST, run_a[ia]);
				ia++;
			end else begin
				send(mtss_pkg::CMD_APPEND_SECOND, run_b[ib]);
				ib++;
			end
			items_sent++;
		end
		if ($urandom_range(0, 9) != 0) begin
			send(mtss_pkg::CMD_START, $urandom);
			items_sent++;
		end
	endtask

	// Receiver: random stalls, plus one long hold-off on request so that a
	// merge backs up and the block stalls its input.
	initial begin : receiver
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_LEN - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= recv_idle);
			end
		end
	end

	// Watchdog: give up after a long stretch with no item moving on either side.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet <= 0;
			else
				quiet <= quiet + 1;
			if (quiet >= QUIET_MAX) begin
				$display("tb_top: errors");
				$finish;
			end
		end
	end

	initial begin : stimulus
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Start with both sequences empty: one result flagged empty.
		send(mtss_pkg::CMD_START, 32'sd0);
		// Unused code: no result, no state change.
		send(CMD_UNUSED, 32'sh8000_0001);
		// First sequence at the extremes and zero.
		send(mtss_pkg::CMD_APPEND_FIRST, VAL_MIN);
		send(mtss_pkg::CMD_APPEND_FIRST, 32'sd0);
		send(mtss_pkg::CMD_APPEND_FIRST, VAL_MAX);
		// Second sequence fills its buffer and overruns by one; it ties the
		// first at the minimum, at zero and at the maximum.
		for (int k = 0; k <= DEPTH; k++) begin
			if (k < 2)
				send(mtss_pkg::CMD_APPEND_SECOND, VAL_MIN);
			else if (k < DEPTH - 1)
				send(mtss_pkg::CMD_APPEND_SECOND, 32'(k * 100 - 700));
			else
				send(mtss_pkg::CMD_APPEND_SECOND, VAL_MAX);
		end
		send(mtss_pkg::CMD_START, 32'sh5a5a_5a5a);
		drain_results();

		// Random rounds in three phases of idling; each phase ends with a full
		// drain. The last phase opens with the long receiver hold-off.
		for (int phase = 0; phase < 3; phase++) begin
			send_idle = (phase == 0) ? 19 : (phase == 1) ? 54 : 0;
			recv_idle = (phase == 0) ? 54 : (phase == 1) ? 19 : 0;
			if (phase == 2)
				hold_req = 1'b1;
			items_sent = 0;
			while (items_sent < 22)
				run_round();
			// close any round left open so that its elements come out here
			send(mtss_pkg::CMD_START, $urandom);
			drain_results();
		end

		repeat (8) @(posedge clk);
		if (fails == 0 && pending == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/mtss_pkg.sv
sv/mtss_buf.sv
sv/mtss_cmp.sv
sv/merge_two_sorted_sequences.sv
tb/merge_order_checker.sv
tb/tb_top.sv
